[src/grid_density_histogram_defines.svh]
// Assertion helpers for the density histogram block
`ifndef GRID_DENSITY_HISTOGRAM_DEFINES_SVH
`define GRID_DENSITY_HISTOGRAM_DEFINES_SVH

// same-cycle implication, quiet during reset
`define GDH_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define GDH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/gdh_pkg.sv]
// ---------------------------------------------------------------------------
// gdh_pkg
// Shared constants, codes and types of the grid density histogram.
// ---------------------------------------------------------------------------
package gdh_pkg;

	localparam int MAX_WIDTH   = 64;
	localparam int MAX_HEIGHT  = 64;
	localparam int MAX_DEPTH   = 16;
	localparam int COUNT_BITS  = 32;
	localparam int ADDR_BITS   = 16;
	localparam int STORE_DEPTH = 65536;

	// item functions
	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_CLEARED = 2'd2;

	// configuration register indexes
	localparam logic [3:0] REG_THREE_DIMS = 4'd0;
	localparam logic [3:0] REG_WIDTH      = 4'd1;
	localparam logic [3:0] REG_HEIGHT     = 4'd2;
	localparam logic [3:0] REG_DEPTH      = 4'd3;
	localparam logic [3:0] REG_OFFSET_X   = 4'd4;
	localparam logic [3:0] REG_OFFSET_Y   = 4'd5;
	localparam logic [3:0] REG_OFFSET_Z   = 4'd6;
	localparam logic [3:0] REG_BIN_WIDTH  = 4'd7;

	typedef struct packed {
		logic        three_dims;
		logic [6:0]  width_bins;
		logic [6:0]  height_bins;
		logic [4:0]  depth_bins;
		logic [31:0] offset_x;
		logic [31:0] offset_y;
		logic [31:0] offset_z;
		logic [30:0] bin_width;
	} cfg_t;

	// classified work word passed from front to back
	typedef struct packed {
		logic [1:0]           func;
		logic                 in_grid;
		logic [ADDR_BITS-1:0] flat;
	} work_t;

endpackage

[src/gdh_front.sv]
// ---------------------------------------------------------------------------
// gdh_front
// Accepts items, finds bin indexes by a bit-serial divider and classifies.
// ---------------------------------------------------------------------------
module gdh_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  gdh_pkg::cfg_t       cfg,
	input  logic [1:0]          func,
	input  logic signed [31:0]  coord_x,
	input  logic signed [31:0]  coord_y,
	input  logic signed [31:0]  coord_z,
	input  logic [5:0]          bin_x,
	input  logic [5:0]          bin_y,
	input  logic [3:0]          bin_z,
	input  logic                q_full,
	output logic                push,
	output gdh_pkg::work_t      push_word,
	output logic                front_busy
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_MAG  = 3'd1;
	localparam logic [2:0] F_DIV  = 3'd2;
	localparam logic [2:0] F_WH   = 3'd3;
	localparam logic [2:0] F_FLAT = 3'd4;
	localparam logic [2:0] F_PUSH = 3'd5;

	logic [2:0]         state_q;
	logic [1:0]         func_q;
	logic signed [32:0] sum_q [3];
	logic [32:0]        rem_q [3];
	logic [5:0]         idx_q [3];
	logic [2:0]         over_q;
	logic [2:0]         step_q;
	logic [13:0]        wh_q;
	logic [12:0]        yw_q;
	logic               inside_q;
	logic [15:0]        flat_q;

	logic [6:0]  w_eff, h_eff, d_lim;
	logic [30:0] bw_eff;
	logic [32:0] mag [3];
	logic [36:0] trial [3];
	logic [36:0] bw_top;

	// clamped grid sizes
	always_comb begin
		w_eff  = (cfg.width_bins == 7'd0) ? 7'd1 :
			(cfg.width_bins > 7'(gdh_pkg::MAX_WIDTH)) ? 7'(gdh_pkg::MAX_WIDTH) : cfg.width_bins;
		h_eff  = (cfg.height_bins == 7'd0) ? 7'd1 :
			(cfg.height_bins > 7'(gdh_pkg::MAX_HEIGHT)) ? 7'(gdh_pkg::MAX_HEIGHT) : cfg.height_bins;
		d_lim  = !cfg.three_dims ? 7'd1 :
			(cfg.depth_bins == 5'd0) ? 7'd1 :
			(cfg.depth_bins > 5'(gdh_pkg::MAX_DEPTH)) ? 7'(gdh_pkg::MAX_DEPTH) :
			{2'b00, cfg.depth_bins};
		bw_eff = (cfg.bin_width == 31'd0) ? 31'd1 : cfg.bin_width;
		bw_top = {bw_eff, 6'd0};
	end

	// magnitudes and divider trial values
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mag[a]   = sum_q[a][32] ? 33'(-sum_q[a]) : 33'(sum_q[a]);
			trial[a] = {6'd0, bw_eff} << step_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						case (func)
							gdh_pkg::FUNC_ADD:  state_q <= F_MAG;
							gdh_pkg::FUNC_READ: state_q <= F_WH;
							default:            state_q <= F_PUSH;
						endcase
					end
				end
				F_MAG:  state_q <= F_DIV;
				F_DIV:  if (step_q == 3'd0) state_q <= F_WH;
				F_WH:   state_q <= F_FLAT;
				F_FLAT: state_q <= F_PUSH;
				F_PUSH: if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				func_q <= func;
				sum_q[0] <= 33'(coord_x) + 33'($signed(cfg.offset_x));
				sum_q[1] <= 33'(coord_y) + 33'($signed(cfg.offset_y));
				sum_q[2] <= cfg.three_dims ?
					33'(coord_z) + 33'($signed(cfg.offset_z)) : 33'sd0;
				idx_q[0] <= bin_x;
				idx_q[1] <= bin_y;
				idx_q[2] <= cfg.three_dims ? {2'b00, bin_z} : 6'd0;
				over_q   <= 3'b000;
			end
			F_MAG: begin
				for (int a = 0; a < 3; a++) begin
					rem_q[a]  <= mag[a];
					over_q[a] <= {4'd0, mag[a]} >= bw_top;
					idx_q[a]  <= 6'd0;
				end
				step_q <= 3'd5;
			end
			F_DIV: begin
				// one quotient bit per axis per cycle
				for (int a = 0; a < 3; a++) begin
					if ({4'd0, rem_q[a]} >= trial[a]) begin
						rem_q[a] <= 33'({4'd0, rem_q[a]} - trial[a]);
						idx_q[a][step_q] <= 1'b1;
					end
				end
				step_q <= step_q - 3'd1;
			end
			F_WH: begin
				wh_q     <= {7'd0, w_eff} * {7'd0, h_eff};
				yw_q     <= {7'd0, idx_q[1]} * {6'd0, w_eff};
				inside_q <= (over_q == 3'b000) && ({1'b0, idx_q[0]} < w_eff) &&
					({1'b0, idx_q[1]} < h_eff) && ({1'b0, idx_q[2]} < d_lim);
			end
			F_FLAT: begin
				flat_q <= {10'd0, idx_q[2]} * {2'd0, wh_q} + {3'd0, yw_q} +
					{10'd0, idx_q[0]};
			end
			default: begin
			end
		endcase
	end

	assign push              = (state_q == F_PUSH) && !q_full;
	assign push_word.func    = func_q;
	assign push_word.in_grid = inside_q;
	assign push_word.flat    = flat_q;
	assign front_busy        = (state_q != F_IDLE);

endmodule

[src/gdh_queue.sv]
// ---------------------------------------------------------------------------
// gdh_queue
// Two-entry queue of classified words between front and back.
// ---------------------------------------------------------------------------
module gdh_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gdh_pkg::work_t push_word,
	input  logic           pop,
	output gdh_pkg::work_t head,
	output logic           empty,
	output logic           full
);

	gdh_pkg::work_t slot_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_word;
	end

	assign head  = slot_q[rd_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

endmodule

[src/gdh_back.sv]
// ---------------------------------------------------------------------------
// gdh_back
// Count store read-modify-write, peak tracking, level divider, clear sweep.
// ---------------------------------------------------------------------------
`include "grid_density_histogram_defines.svh"

module gdh_back (
	input  logic           clk,
	input  logic           arst_n,
	input  gdh_pkg::work_t head,
	input  logic           q_empty,
	output logic           pop,
	output logic           sweeping,
	output logic           done,
	output logic [1:0]     status,
	output logic [15:0]    flat_index,
	output logic [31:0]    raw_count,
	output logic [7:0]     level,
	output logic [31:0]    peak_count
);

	localparam int CB = gdh_pkg::COUNT_BITS;
	localparam int AB = gdh_pkg::ADDR_BITS;

	localparam logic [2:0] B_CLR  = 3'd0;
	localparam logic [2:0] B_IDLE = 3'd1;
	localparam logic [2:0] B_CALC = 3'd2;
	localparam logic [2:0] B_LVL  = 3'd3;
	localparam logic [2:0] B_OUT  = 3'd4;

	logic [CB-1:0]  mem [gdh_pkg::STORE_DEPTH];
	logic [CB-1:0]  rdata_q;
	logic [2:0]     state_q;
	logic [AB-1:0]  clr_addr_q;
	logic           clr_item_q;
	logic [1:0]     func_q;
	logic [AB-1:0]  flat_q;
	logic [1:0]     status_q;
	logic [CB-1:0]  count_q;
	logic [CB-1:0]  peak_q;
	logic [7:0]     lvl_q;
	logic [CB+7:0]  rem_q;
	logic [2:0]     step_q;

	logic           we;
	logic [AB-1:0]  waddr;
	logic [CB-1:0]  wdata;
	logic [CB-1:0]  cnt_new;
	logic [CB-1:0]  peak_new;
	logic [CB+7:0]  trial;
	logic           is_add;

	assign pop    = (state_q == B_IDLE) && !q_empty;
	assign is_add = (func_q == gdh_pkg::FUNC_ADD);

	// saturating increment and peak follow
	always_comb begin
		cnt_new  = (is_add && (rdata_q != {CB{1'b1}})) ? rdata_q + 1'b1 : rdata_q;
		peak_new = (is_add && (cnt_new > peak_q)) ? cnt_new : peak_q;
		trial    = {8'd0, peak_q} << step_q;
	end

	// store write port: sweep or add write-back
	always_comb begin
		we    = 1'b0;
		waddr = clr_addr_q;
		wdata = '0;
		if (state_q == B_CLR) begin
			we = 1'b1;
		end else if (state_q == B_CALC && is_add) begin
			we    = 1'b1;
			waddr = flat_q;
			wdata = cnt_new;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (pop) rdata_q <= mem[head.flat];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_CLR;
			clr_addr_q <= '0;
			clr_item_q <= 1'b0;
			peak_q     <= '0;
		end else begin
			case (state_q)
				B_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == {AB{1'b1}}) begin
						state_q    <= clr_item_q ? B_OUT : B_IDLE;
						clr_item_q <= 1'b0;
					end
				end
				B_IDLE: begin
					if (!q_empty) begin
						if (head.func == gdh_pkg::FUNC_CLEAR) begin
							state_q    <= B_CLR;
							clr_addr_q <= '0;
							clr_item_q <= 1'b1;
							peak_q     <= '0;
						end else if ((head.func == gdh_pkg::FUNC_ADD ||
							head.func == gdh_pkg::FUNC_READ) && head.in_grid) begin
							state_q <= B_CALC;
						end else begin
							state_q <= B_OUT;
						end
					end
				end
				B_CALC: begin
					peak_q <= peak_new;
					if (peak_new == '0 || cnt_new >= peak_new) state_q <= B_OUT;
					else state_q <= B_LVL;
				end
				B_LVL: if (step_q == 3'd0) state_q <= B_OUT;
				B_OUT: state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// result and level datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				func_q   <= head.func;
				flat_q   <= ((head.func == gdh_pkg::FUNC_ADD ||
					head.func == gdh_pkg::FUNC_READ) && head.in_grid) ? head.flat : '0;
				status_q <= (head.func == gdh_pkg::FUNC_CLEAR) ? gdh_pkg::ST_CLEARED :
					gdh_pkg::ST_OUTSIDE;
				count_q  <= '0;
				lvl_q    <= 8'd0;
			end
			B_CALC: begin
				status_q <= gdh_pkg::ST_DONE;
				count_q  <= cnt_new;
				lvl_q    <= (peak_new == '0 || cnt_new < peak_new) ? 8'd0 : 8'd255;
				rem_q    <= {cnt_new, 8'd0} - {8'd0, cnt_new};
				step_q   <= 3'd7;
			end
			B_LVL: begin
				// restoring divide of count*255 by peak, one bit per cycle
				if (rem_q >= trial) begin
					rem_q         <= rem_q - trial;
					lvl_q[step_q] <= 1'b1;
				end
				step_q <= step_q - 3'd1;
			end
			default: begin
			end
		endcase
	end

	assign sweeping   = (state_q == B_CLR);
	assign done       = (state_q == B_OUT);
	assign status     = status_q;
	assign flat_index = 16'(flat_q);
	assign raw_count  = count_q[31:0];
	assign level      = lvl_q;
	assign peak_count = peak_q[31:0];

	`GDH_ASSERT_IMPL(a_count_le_peak, done && status_q == gdh_pkg::ST_DONE, count_q <= peak_q, "count above peak")
	`GDH_ASSERT_IMPL(a_pop_idle, pop, state_q == B_IDLE && !sweeping, "pop outside idle")
	`GDH_ASSERT_NEXT(a_clear_peak, pop && head.func == gdh_pkg::FUNC_CLEAR, peak_q == '0 && sweeping, "clear did not reset peak")

endmodule

[src/grid_density_histogram.sv]
// ---------------------------------------------------------------------------
// grid_density_histogram
// Bins Q16.16 points into a 2D/3D count grid with peak and level readout.
// ---------------------------------------------------------------------------
// Usage:
//   Items: drive func and payload with start high; the item is taken at an
//   edge where busy is low. Each item gives one result word, shown with
//   done high for one cycle; the receiver cannot stall, so nothing waits.
//   Configuration: cfg_valid/cfg_index/cfg_data, cfg_ready always high;
//   write only while the block is idle.
//   An add passes through a magnitude step, a bit-serial divide for the
//   bin index, range check and flat index, and the queue push, then the
//   pop with store read, update, level-divider steps where needed, and
//   output; a read skips the magnitude and divider steps.
//   The front is free again once its word is queued, so it can take a new
//   item while the back still works on earlier words if the queue has
//   room; a run of reads is paced by the back's level divide.
//   Clear walks the whole 65536-entry store, one entry a cycle, and then
//   reports. After reset the same clearing pass runs and busy stays high
//   until it is over; configuration writes are taken meanwhile.
// ---------------------------------------------------------------------------
module grid_density_histogram (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic [5:0]         bin_x,
	input  logic [5:0]         bin_y,
	input  logic [3:0]         bin_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic [1:0]         status,
	output logic [15:0]        flat_index,
	output logic [31:0]        raw_count,
	output logic [7:0]         level,
	output logic [31:0]        peak_count
);

	gdh_pkg::cfg_t  cfg_q;
	gdh_pkg::work_t push_word, head;
	logic           accept, push, pop, q_empty, q_full, front_busy, sweeping;

	assign cfg_ready = 1'b1;
	assign busy      = front_busy || q_full || sweeping;
	assign accept    = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.three_dims  <= 1'b0;
			cfg_q.width_bins  <= 7'd64;
			cfg_q.height_bins <= 7'd64;
			cfg_q.depth_bins  <= 5'd16;
			cfg_q.offset_x    <= '0;
			cfg_q.offset_y    <= '0;
			cfg_q.offset_z    <= '0;
			cfg_q.bin_width   <= 31'd65536;
		end else if (cfg_valid) begin
			case (cfg_index)
				gdh_pkg::REG_THREE_DIMS: cfg_q.three_dims  <= cfg_data[0];
				gdh_pkg::REG_WIDTH:      cfg_q.width_bins  <= cfg_data[6:0];
				gdh_pkg::REG_HEIGHT:     cfg_q.height_bins <= cfg_data[6:0];
				gdh_pkg::REG_DEPTH:      cfg_q.depth_bins  <= cfg_data[4:0];
				gdh_pkg::REG_OFFSET_X:   cfg_q.offset_x    <= cfg_data;
				gdh_pkg::REG_OFFSET_Y:   cfg_q.offset_y    <= cfg_data;
				gdh_pkg::REG_OFFSET_Z:   cfg_q.offset_z    <= cfg_data;
				gdh_pkg::REG_BIN_WIDTH:  cfg_q.bin_width   <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	gdh_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .cfg(cfg_q), .func(func),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.bin_x(bin_x), .bin_y(bin_y), .bin_z(bin_z), .q_full(q_full),
		.push(push), .push_word(push_word), .front_busy(front_busy)
	);

	gdh_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_word(push_word),
		.pop(pop), .head(head), .empty(q_empty), .full(q_full)
	);

	gdh_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .q_empty(q_empty), .pop(pop),
		.sweeping(sweeping), .done(done), .status(status), .flat_index(flat_index),
		.raw_count(raw_count), .level(level), .peak_count(peak_count)
	);

endmodule

[tb/gdh_checker.sv]
// ---------------------------------------------------------------------------
// gdh_checker
// Watches the item, config and result channels of the histogram block. Keeps
// its own copy of the grid, peak and settings, works out each result word
// when an item is taken, and compares the result words in order.
// ---------------------------------------------------------------------------
module gdh_checker
	import gdh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         func,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic [5:0]         bin_x,
	input  logic [5:0]         bin_y,
	input  logic [3:0]         bin_z,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic [15:0]        flat_index,
	input  logic [31:0]        raw_count,
	input  logic [7:0]         level,
	input  logic [31:0]        peak_count,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] flat_index;
		logic [31:0] raw_count;
		logic [7:0]  level;
		logic [31:0] peak_count;
	} bin_word_t;

	cfg_t            shadow_cfg;
	int unsigned     grid_counts [int unsigned];
	int unsigned     grid_peak;
	bin_word_t       expected_words [$];

	assign pending = expected_words.size();

	// clamp a bin-count register to 1..maxv
	function automatic int unsigned clamp_bins(int unsigned v, int unsigned maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	// bin index along one axis: |coord+offset| / bin width, no wrap
	function automatic longint unsigned axis_bin(logic [31:0] c, logic [31:0] off);
		longint sum;
		longint unsigned mag;
		longint unsigned bw;
		sum = longint'(signed'(c)) + longint'(signed'(off));
		mag = (sum < 0) ? longint'(-sum) : longint'(sum);
		bw  = (shadow_cfg.bin_width == 0) ? 1 : shadow_cfg.bin_width;
		return mag / bw;
	endfunction

	function automatic logic [7:0] level_of(int unsigned c);
		longint unsigned q;
		if (grid_peak == 0) return 8'd0;
		if (c >= grid_peak) return 8'd255;
		q = (longint'(c) * 255) / grid_peak;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	// advance the grid by one item and return its result word
	function automatic bin_word_t bin_step();
		bin_word_t   w;
		int unsigned nw, nh, nd, flat;
		longint unsigned ix, iy, iz;
		nw = clamp_bins(shadow_cfg.width_bins, MAX_WIDTH);
		nh = clamp_bins(shadow_cfg.height_bins, MAX_HEIGHT);
		nd = clamp_bins(shadow_cfg.depth_bins, MAX_DEPTH);
		w = '{status: ST_OUTSIDE, flat_index: 0, raw_count: 0, level: 0,
			peak_count: grid_peak};
		if (func == FUNC_CLEAR) begin
			grid_counts.delete();
			grid_peak = 0;
			w.status = ST_CLEARED;
			w.peak_count = 0;
			return w;
		end
		if (func != FUNC_ADD && func != FUNC_READ) return w;
		if (func == FUNC_ADD) begin
			ix = axis_bin(coord_x, shadow_cfg.offset_x);
			iy = axis_bin(coord_y, shadow_cfg.offset_y);
			iz = shadow_cfg.three_dims ? axis_bin(coord_z, shadow_cfg.offset_z) : 0;
		end else begin
			ix = bin_x;
			iy = bin_y;
			iz = shadow_cfg.three_dims ? bin_z : 0;
		end
		if (ix >= nw || iy >= nh || iz >= (shadow_cfg.three_dims ? nd : 1)) return w;
		flat = int'(iz) * nw * nh + int'(iy) * nw + int'(ix);
		if (!grid_counts.exists(flat)) grid_counts[flat] = 0;
		if (func == FUNC_ADD) begin
			if (grid_counts[flat] != 32'hFFFF_FFFF) grid_counts[flat]++;
			if (grid_counts[flat] > grid_peak) grid_peak = grid_counts[flat];
		end
		w.status = ST_DONE;
		w.flat_index = flat[15:0];
		w.raw_count = grid_counts[flat];
		w.level = level_of(grid_counts[flat]);
		w.peak_count = grid_peak;
		return w;
	endfunction

	// settings, predictions and comparisons, all on the rising edge
	always @(posedge clk or negedge arst_n) begin
		bin_word_t e;
		if (!arst_n) begin
			shadow_cfg <= '{three_dims: 0, width_bins: 64, height_bins: 64, depth_bins: 16,
				offset_x: 0, offset_y: 0, offset_z: 0, bin_width: 65536};
			grid_counts.delete();
			grid_peak = 0;
			expected_words.delete();
			fail_count = 0;
		end else begin
			if (done) begin
				if (expected_words.size() == 0) begin
					$display("%0t: result word with nothing expected: %h", $time,
						{status, flat_index, raw_count, level, peak_count});
					fail_count++;
				end else begin
					e = expected_words.pop_front();
					if (e.status !== status) begin
						$display("%0t: status exp %0d got %0d", $time, e.status, status);
						fail_count++;
					end
					if (e.flat_index !== flat_index) begin
						$display("%0t: flat_index exp %0d got %0d", $time, e.flat_index,
							flat_index);
						fail_count++;
					end
					if (e.raw_count !== raw_count) begin
						$display("%0t: raw_count exp %0d got %0d", $time, e.raw_count,
							raw_count);
						fail_count++;
					end
					if (e.level !== level) begin
						$display("%0t: level exp %0d got %0d", $time, e.level, level);
						fail_count++;
					end
					if (e.peak_count !== peak_count) begin
						$display("%0t: peak_count exp %0d got %0d", $time, e.peak_count,
							peak_count);
						fail_count++;
					end
				end
			end
			if (start && !busy) expected_words.push_back(bin_step());
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_THREE_DIMS: shadow_cfg.three_dims  <= cfg_data[0];
					REG_WIDTH:      shadow_cfg.width_bins  <= cfg_data[6:0];
					REG_HEIGHT:     shadow_cfg.height_bins <= cfg_data[6:0];
					REG_DEPTH:      shadow_cfg.depth_bins  <= cfg_data[4:0];
					REG_OFFSET_X:   shadow_cfg.offset_x    <= cfg_data;
					REG_OFFSET_Y:   shadow_cfg.offset_y    <= cfg_data;
					REG_OFFSET_Z:   shadow_cfg.offset_z    <= cfg_data;
					REG_BIN_WIDTH:  shadow_cfg.bin_width   <= cfg_data[30:0];
					default: ;
				endcase
			end
		end
	end

endmodule

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Drives the histogram block through a series of grid settings: a directed
// set of adds, reads, clears and an unknown function, then random points
// aimed mostly inside the grid, with random sender gaps. The checker
// beside the block predicts and compares every result word.
// ---------------------------------------------------------------------------
module tb_top;
	import gdh_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int SETTLE      = 40;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         func;
	logic signed [31:0] coord_x, coord_y, coord_z;
	logic [5:0]         bin_x, bin_y;
	logic [3:0]         bin_z;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [3:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               done;
	logic [1:0]         status;
	logic [15:0]        flat_index;
	logic [31:0]        raw_count;
	logic [7:0]         level;
	logic [31:0]        peak_count;
	int                 fail_count;
	int                 pending;
	int                 cycles;
	bit                 gaps_on;

	// settings of the current phase, used to aim points
	int unsigned        cur_w, cur_h, cur_d, cur_bw;
	logic [31:0]        cur_ox, cur_oy, cur_oz;

	grid_density_histogram DUT (.*);

	gdh_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one register write on the config channel
	task automatic write_reg(logic [3:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_grid(bit td, int unsigned w, int unsigned h, int unsigned d,
			logic [31:0] ox, logic [31:0] oy, logic [31:0] oz, int unsigned bw);
		write_reg(REG_THREE_DIMS, {31'(0), td});
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_DEPTH, d);
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_OFFSET_Y, oy);
		write_reg(REG_OFFSET_Z, oz);
		write_reg(REG_BIN_WIDTH, bw);
		cur_w  = (w[6:0] == 0) ? 1 : (w[6:0] > 64 ? 64 : w[6:0]);
		cur_h  = (h[6:0] == 0) ? 1 : (h[6:0] > 64 ? 64 : h[6:0]);
		cur_d  = (d[4:0] == 0) ? 1 : (d[4:0] > 16 ? 16 : d[4:0]);
		cur_bw = (bw[30:0] == 0) ? 1 : bw[30:0];
		cur_ox = ox;
		cur_oy = oy;
		cur_oz = oz;
	endtask

	// present one item word and hold it until taken
	task automatic send_item(logic [1:0] f, logic [31:0] cx, logic [31:0] cy,
			logic [31:0] cz, logic [5:0] bx, logic [5:0] by, logic [3:0] bz);
		@(negedge clk);
		start   <= 1'b1;
		func    <= f;
		coord_x <= cx;
		coord_y <= cy;
		coord_z <= cz;
		bin_x   <= bx;
		bin_y   <= by;
		bin_z   <= bz;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
	endtask

	// drain: let every result come, then let the back end settle
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// coordinate that lands in bin 0..nbins (one past the edge now and then)
	function automatic logic [31:0] aim(int unsigned nbins, logic [31:0] off);
		longint mag;
		longint sum;
		mag = longint'($urandom_range(0, nbins)) * cur_bw + ($urandom % cur_bw);
		sum = $urandom_range(0, 1) ? -mag : mag;
		return 32'(sum - longint'(signed'(off)));
	endfunction

	task automatic random_items(int n);
		int k;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: send_item(FUNC_ADD, aim(cur_w, cur_ox), aim(cur_h, cur_oy),
					aim(cur_d, cur_oz), $urandom, $urandom, $urandom);
				6: send_item(FUNC_ADD, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
				7, 8: send_item(FUNC_READ, $urandom, $urandom, $urandom,
					$urandom_range(0, cur_w), $urandom_range(0, cur_h),
					$urandom_range(0, cur_d));
				default: send_item($urandom_range(0, 1) ? FUNC_READ : 2'd3, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom);
			endcase
			// hold the sender back until the block is empty, once per call
			if (k == n / 2) begin
				@(negedge clk);
				start <= 1'b0;
				wait (pending == 0);
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		func      = FUNC_ADD;
		coord_x   = '0;
		coord_y   = '0;
		coord_z   = '0;
		bin_x     = '0;
		bin_y     = '0;
		bin_z     = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		cycles    = 0;
		gaps_on   = 1'b1;
		cur_w = 64; cur_h = 64; cur_d = 16; cur_bw = 65536;
		cur_ox = 0; cur_oy = 0; cur_oz = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, 2D, unit bins
		send_item(FUNC_ADD, 32'h0, 32'h0, 32'h0, 0, 0, 0);
		send_item(FUNC_ADD, 32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_FFFF, 0, 0, 0);
		send_item(FUNC_ADD, 32'h003F_FFFF, 32'h003F_0000, 32'h0, 0, 0, 0);
		send_item(FUNC_ADD, 32'hFFC0_0001, 32'h0, 32'h8000_0000, 0, 0, 0);
		send_item(FUNC_ADD, 32'h0040_0000, 32'h0, 32'h0, 0, 0, 0);
		send_item(FUNC_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0, 0, 0);
		send_item(FUNC_READ, 0, 0, 0, 6'd0, 6'd0, 4'd15);
		send_item(FUNC_READ, 0, 0, 0, 6'd63, 6'd63, 4'd0);
		send_item(FUNC_READ, 0, 0, 0, 6'd63, 6'd0, 4'd0);
		send_item(FUNC_READ, 0, 0, 0, 6'd5, 6'd7, 4'd3);
		send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F, 6'h3F, 4'hF);
		send_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
		send_item(FUNC_READ, 0, 0, 0, 6'd0, 6'd0, 4'd0);
		send_item(FUNC_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0, 0, 0, 0);
		drain();

		// directed: 3D with extreme register values
		set_grid(1, 127, 0, 31, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 0);
		send_item(FUNC_ADD, 32'h8000_0000, 32'h8000_0000, 32'h0, 0, 0, 0);
		send_item(FUNC_ADD, 32'h7FFF_FFC1, 32'h8000_0001, 32'h0000_000F, 0, 0, 0);
		send_item(FUNC_READ, 0, 0, 0, 6'd63, 6'd0, 4'd15);
		send_item(FUNC_READ, 0, 0, 0, 6'd0, 6'd1, 4'd0);
		random_items(60);
		drain();

		set_grid(1, 8, 8, 4, 32'h0005_0000, 32'hFFFD_0000, 32'h0001_0000, 32'h8000);
		random_items(150);
		drain();

		set_grid(0, 1, 1, 0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		random_items(80);
		drain();

		set_grid(1, 64, 64, 16, $urandom, $urandom, $urandom, 32'h0002_0000);
		random_items(150);
		send_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
		random_items(60);
		drain();

		set_grid(0, 13, 37, 5, 32'h0000_0100, 32'hFFFF_FF00, 32'h0, 3);
		random_items(130);
		drain();

		// last stretch: no gaps
		set_grid(1, 3, 2, 2, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
		gaps_on = 1'b0;
		random_items(200);
		drain();

		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/gdh_pkg.sv
src/gdh_front.sv
src/gdh_queue.sv
src/gdh_back.sv
src/grid_density_histogram.sv
tb/gdh_checker.sv
tb/tb_top.sv
